// File: rtl/i2cm_pkg.sv
package i2cm_pkg;

   // command codes on the request channel
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // last step index of each sequence
   localparam logic [4:0] START_LAST = 5'd3;
   localparam logic [4:0] STOP_LAST  = 5'd2;
   localparam logic [4:0] WRITE_LAST = 5'd26;
   localparam logic [4:0] READ_LAST  = 5'd20;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_NOP  = 2'd0,
      KIND_TICK = 2'd1,
      KIND_CMD  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      op_type     op;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic idle;
   } bk_status_type;

endpackage

// File: rtl/i2cm_front.sv
module i2cm_front (
   input  logic [2:0]        req_command,
   input  logic [7:0]        req_tx_byte,
   input  logic              req_send_ack,
   input  logic              req_sda_sample,
   output i2cm_pkg::item_type item
);
   import i2cm_pkg::*;

   // classify the command code
   always_comb begin
      item.tx_byte    = req_tx_byte;
      item.send_ack   = req_send_ack;
      item.sda_sample = req_sda_sample;
      case (req_command)
         CMD_TICK: begin
            item.kind = KIND_TICK;
            item.op   = OP_IDLE;
         end
         CMD_START: begin
            item.kind = KIND_CMD;
            item.op   = OP_START;
         end
         CMD_STOP: begin
            item.kind = KIND_CMD;
            item.op   = OP_STOP;
         end
         CMD_WRITE: begin
            item.kind = KIND_CMD;
            item.op   = OP_WRITE;
         end
         CMD_READ: begin
            item.kind = KIND_CMD;
            item.op   = OP_READ;
         end
         default: begin
            item.kind = KIND_NOP;
            item.op   = OP_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/i2cm_queue.sv
module i2cm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  i2cm_pkg::item_type      push_item,
   input  logic                    pop,
   output i2cm_pkg::item_type      pop_item,
   output i2cm_pkg::q_status_type  status
);
   import i2cm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/i2cm_back.sv
module i2cm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  i2cm_pkg::item_type       q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_scl_level,
   output logic                     rsp_sda_level,
   output logic [7:0]               rsp_rx_byte,
   output logic                     rsp_nack_seen,
   output logic                     rsp_done_res,
   output logic                     rsp_rejected,
   output i2cm_pkg::bk_status_type  status
);
   import i2cm_pkg::*;

   op_type     active_op_ff, active_op_in;
   logic [4:0] step_ff, step_in;
   logic [7:0] shift_out_ff, shift_out_in;
   logic [7:0] shift_in_ff, shift_in_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       ack_result_ff, ack_result_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       rsp_rej_ff, rsp_rej_in;
   logic       rsp_scl_ff, rsp_sda_ff;
   logic [7:0] rsp_rx_ff;
   logic       rsp_nack_ff;

   logic       advance;
   logic       last;
   logic [2:0] wr_bit;
   logic [1:0] wr_phase;
   logic [7:0] wr_prod;
   logic [4:0] wr_rem;

   assign q_pop       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign status.idle = (active_op_ff == OP_IDLE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = rsp_scl_ff;
   assign rsp_sda_level = rsp_sda_ff;
   assign rsp_rx_byte   = rsp_rx_ff;
   assign rsp_nack_seen = rsp_nack_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_rejected  = rsp_rej_ff;

   always_comb begin
      active_op_in  = active_op_ff;
      step_in       = step_ff;
      shift_out_in  = shift_out_ff;
      shift_in_in   = shift_in_ff;
      ack_choice_in = ack_choice_ff;
      ack_result_in = ack_result_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rsp_done_in   = 1'b0;
      rsp_rej_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      advance       = 1'b0;
      last          = 1'b0;
      wr_bit        = 3'd0;
      wr_phase      = 2'd0;
      wr_prod       = 8'd0;
      wr_rem        = 5'd0;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         case (q_item.kind)
            KIND_CMD: begin
               if (active_op_ff != OP_IDLE) begin
                  rsp_rej_in = 1'b1;
               end else begin
                  active_op_in = q_item.op;
                  step_in      = 5'd0;
                  advance      = 1'b1;
                  if (q_item.op == OP_WRITE) begin
                     shift_out_in  = q_item.tx_byte;
                     ack_result_in = 1'b0;
                  end
                  if (q_item.op == OP_READ) begin
                     shift_in_in   = 8'd0;
                     ack_choice_in = q_item.send_ack;
                  end
               end
            end
            KIND_TICK: begin
               advance = (active_op_ff != OP_IDLE);
            end
            default: begin
               advance = 1'b0;
            end
         endcase

         if (advance) begin
            case (active_op_in)
               OP_START: begin
                  case (step_in)
                     5'd0: sda_in = 1'b1;
                     5'd1: scl_in = 1'b1;
                     5'd2: sda_in = 1'b0;
                     default: begin
                        scl_in = 1'b0;
                        last   = 1'b1;
                     end
                  endcase
               end
               OP_STOP: begin
                  case (step_in)
                     5'd0: sda_in = 1'b0;
                     5'd1: scl_in = 1'b1;
                     default: begin
                        sda_in = 1'b1;
                        last   = 1'b1;
                     end
                  endcase
               end
               OP_WRITE: begin
                  if (step_in < 5'd24) begin
                     // bit index is step / 3 via multiply by 11 and shift, exact below 24
                     wr_prod  = {3'd0, step_in} * 8'd11;
                     wr_bit   = wr_prod[7:5];
                     wr_rem   = step_in - ({1'b0, wr_bit, 1'b0} + {2'b00, wr_bit});
                     wr_phase = wr_rem[1:0];
                     if (wr_phase == 2'd0) begin
                        sda_in = shift_out_in[3'd7 - wr_bit];
                     end else if (wr_phase == 2'd1) begin
                        scl_in = 1'b1;
                     end else begin
                        scl_in = 1'b0;
                     end
                  end else if (step_in == 5'd24) begin
                     sda_in = 1'b1;
                  end else if (step_in == 5'd25) begin
                     scl_in = 1'b1;
                  end else begin
                     if (step_in == WRITE_LAST) begin
                        scl_in        = 1'b0;
                        ack_result_in = q_item.sda_sample;
                     end
                     last = 1'b1;
                  end
               end
               OP_READ: begin
                  if (step_in == 5'd0) begin
                     sda_in = 1'b1;
                  end else if (step_in <= 5'd16) begin
                     if (step_in[0]) begin
                        scl_in = 1'b1;
                     end else begin
                        scl_in      = 1'b0;
                        shift_in_in = {shift_in_in[6:0], q_item.sda_sample};
                     end
                  end else if (step_in == 5'd17) begin
                     sda_in = !ack_choice_in;
                  end else if (step_in == 5'd18) begin
                     scl_in = 1'b1;
                  end else if (step_in == 5'd19) begin
                     scl_in = 1'b0;
                  end else begin
                     if (step_in == READ_LAST) begin
                        sda_in = 1'b1;
                     end
                     last = 1'b1;
                  end
               end
               default: begin
                  last = 1'b1;
               end
            endcase

            if (last) begin
               rsp_done_in  = 1'b1;
               active_op_in = OP_IDLE;
               step_in      = 5'd0;
            end else begin
               step_in = step_in + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_op_ff  <= OP_IDLE;
         step_ff       <= 5'd0;
         shift_out_ff  <= 8'd0;
         shift_in_ff   <= 8'd0;
         ack_choice_ff <= 1'b0;
         ack_result_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_op_ff  <= active_op_in;
         step_ff       <= step_in;
         shift_out_ff  <= shift_out_in;
         shift_in_ff   <= shift_in_in;
         ack_choice_ff <= ack_choice_in;
         ack_result_ff <= ack_result_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result register, loaded together with the state
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_rx_ff   <= shift_in_in;
         rsp_nack_ff <= ack_result_in;
         rsp_done_ff <= rsp_done_in;
         rsp_rej_ff  <= rsp_rej_in;
      end
   end

endmodule

// File: rtl/i2c_master_byte_engine.sv
// i2c master line engine, pin level
// request channel (req_*): one item per line step. a command (start, stop,
//   write byte, read byte) opens a sequence and yields its first scl/sda
//   step; each later tick yields the next step. start 4 steps, stop 3,
//   write 27, read 21. sda_sample carries the line level seen with the item
// result channel (rsp_*): exactly one result per request, in order, with the
//   scl/sda levels to drive, the read byte, the write nack flag, done on the
//   last step and rejected for a command that arrives mid-sequence
// a taken request is written into the queue, then popped into the result
//   register when the result channel is free
// throughput: one request per cycle sustained while rsp_ready stays high; the
//   back-end sequencer performs one full line step per cycle
// a two-entry queue sits between decode and sequencer; when rsp_ready stays
//   low the queue absorbs two requests, then req_ready drops
// reset: lines released (scl and sda high), sequencer idle, shift registers
//   and ack flags cleared, queue and result register empty
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_nack_seen,
   output logic       rsp_done_res,
   output logic       rsp_rejected
);
   import i2cm_pkg::*;

   item_type      dec_item;
   item_type      q_item;
   q_status_type  q_stat;
   bk_status_type bk_stat;
   logic          q_push;
   logic          q_pop;

   // front end: classify the incoming request
   i2cm_front u_front (
      .req_command    (req_command),
      .req_tx_byte    (req_tx_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_sample (req_sda_sample),
      .item           (dec_item)
   );

   // request taken whenever the queue has room
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;

   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (dec_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .status    (q_stat)
   );

   // back end: line sequencer and result register
   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (!q_stat.empty),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_nack_seen (rsp_nack_seen),
      .rsp_done_res  (rsp_done_res),
      .rsp_rejected  (rsp_rejected),
      .status        (bk_stat)
   );

   // a finished sequence leaves the sequencer idle while its result waits
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> bk_stat.idle)
      else $error("done result while sequencer busy");

   // a rejected command means a sequence was still running
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !bk_stat.idle)
      else $error("rejected result while sequencer idle");

   // done and rejected never on the same result
   a_done_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_rejected))
      else $error("done and rejected together");

   // a popped request always lands in the result register
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("popped request produced no result");

endmodule
